// ----- rtl/srd_pkg.sv -----
// Shared types and constants for the stitch record decoder.
// No dependencies; used by srd_parser and stitch_record_decoder.
`default_nettype none

package srd_pkg;

    // Parse phase of the byte stream
    typedef enum logic [2:0] {
        PH_LEAD      = 3'd0,
        PH_SECOND    = 3'd1,
        PH_JX_HI     = 3'd2,
        PH_JY_LO     = 3'd3,
        PH_C1_FIRST  = 3'd4,
        PH_JY_HI     = 3'd5,
        PH_C1_SECOND = 3'd6
    } phase_t;

    // Kind of an emitted stitch record
    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_TRIM   = 2'd1,
        KIND_STOP   = 2'd2
    } kind_t;

    // Lead and control byte codes
    localparam logic [7:0] LEAD_JUMP_A   = 8'h7E;
    localparam logic [7:0] LEAD_JUMP_B   = 8'h7D;
    localparam logic [7:0] LEAD_CTRL     = 8'h7F;
    localparam logic [7:0] CTRL_SKIP_A   = 8'h17;
    localparam logic [7:0] CTRL_SKIP_B   = 8'h46;
    localparam logic [7:0] CTRL_STOP_MIN = 8'h08;
    localparam logic [7:0] CTRL_DELTA    = 8'h01;

    // One decoded stitch record
    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        kind_t              kind;
    } record_t;

    // Parser result for the byte on offer
    typedef struct packed {
        logic    emit;
        record_t rec;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/srd_parser.sv -----
// Stitch stream parser: parse state registers and per-byte decode logic.
// Depends on srd_pkg.
`default_nettype none

module srd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      byte_in,
    input  wire logic            step,
    output srd_pkg::result_t     result
);

    srd_pkg::phase_t    phase_reg, phase_next;
    logic [7:0]         lead_reg, lead_next;
    logic [7:0]         low_reg, low_next;
    logic [15:0]        x_reg, x_next;
    logic               trim_reg, trim_next;

    // Decode the byte and work out the next parse state
    always_comb
    begin
        phase_next        = phase_reg;
        lead_next         = lead_reg;
        low_next          = low_reg;
        x_next            = x_reg;
        trim_next         = trim_reg;
        result.emit       = 1'b0;
        result.rec.dx     = '0;
        result.rec.dy     = '0;
        result.rec.kind   = srd_pkg::KIND_NORMAL;
        case (phase_reg)
            srd_pkg::PH_SECOND:
            begin
                trim_next  = 1'b0;
                phase_next = srd_pkg::PH_LEAD;
                if (lead_reg == srd_pkg::LEAD_JUMP_A || lead_reg == srd_pkg::LEAD_JUMP_B)
                begin
                    low_next   = byte_in;
                    phase_next = srd_pkg::PH_JX_HI;
                end
                else if (lead_reg == srd_pkg::LEAD_CTRL)
                begin
                    if (byte_in != srd_pkg::CTRL_SKIP_A && byte_in != srd_pkg::CTRL_SKIP_B
                        && byte_in >= srd_pkg::CTRL_STOP_MIN)
                    begin
                        // stop: zero move, trim the following record
                        trim_next       = 1'b1;
                        result.emit     = 1'b1;
                        result.rec.kind = srd_pkg::KIND_STOP;
                    end
                    else if (byte_in == srd_pkg::CTRL_DELTA)
                    begin
                        phase_next = srd_pkg::PH_C1_FIRST;
                    end
                end
                else
                begin
                    result.emit     = 1'b1;
                    result.rec.dx   = $signed({{8{lead_reg[7]}}, lead_reg});
                    result.rec.dy   = $signed({{8{byte_in[7]}}, byte_in});
                    result.rec.kind = trim_reg ? srd_pkg::KIND_TRIM : srd_pkg::KIND_NORMAL;
                end
            end
            srd_pkg::PH_JX_HI:
            begin
                x_next     = {byte_in, low_reg};
                phase_next = srd_pkg::PH_JY_LO;
            end
            srd_pkg::PH_JY_LO:
            begin
                low_next   = byte_in;
                phase_next = srd_pkg::PH_JY_HI;
            end
            srd_pkg::PH_JY_HI:
            begin
                phase_next      = srd_pkg::PH_LEAD;
                result.emit     = 1'b1;
                result.rec.dx   = $signed(x_reg);
                result.rec.dy   = $signed({byte_in, low_reg});
                result.rec.kind = srd_pkg::KIND_TRIM;
            end
            srd_pkg::PH_C1_FIRST:
            begin
                lead_next  = byte_in;
                phase_next = srd_pkg::PH_C1_SECOND;
            end
            srd_pkg::PH_C1_SECOND:
            begin
                phase_next      = srd_pkg::PH_LEAD;
                result.emit     = 1'b1;
                result.rec.dx   = $signed({{8{lead_reg[7]}}, lead_reg});
                result.rec.dy   = $signed({{8{byte_in[7]}}, byte_in});
                result.rec.kind = srd_pkg::KIND_TRIM;
            end
            default:
            begin
                // lead byte, also the recovery path for an unused phase code
                lead_next  = byte_in;
                phase_next = srd_pkg::PH_SECOND;
            end
        endcase
    end

    // Advance the parse state when the byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= srd_pkg::PH_LEAD;
            lead_reg  <= '0;
            low_reg   <= '0;
            x_reg     <= '0;
            trim_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            lead_reg  <= lead_next;
            low_reg   <= low_next;
            x_reg     <= x_next;
            trim_reg  <= trim_next;
        end
    end

    // A stop record always leaves a pending trim behind
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.emit && result.rec.kind == srd_pkg::KIND_STOP |=> trim_reg)
        else $error("stop record did not set pending trim");

    // The last byte of a big jump always completes a trim record
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == srd_pkg::PH_JY_HI |->
            result.emit && result.rec.kind == srd_pkg::KIND_TRIM)
        else $error("big jump did not complete as trim record");

    // Only record-closing phases may produce a word
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != srd_pkg::PH_SECOND && phase_reg != srd_pkg::PH_JY_HI
            && phase_reg != srd_pkg::PH_C1_SECOND |-> !result.emit)
        else $error("record emitted mid-record");

endmodule

`default_nettype wire

// ----- rtl/stitch_record_decoder.sv -----
// Stitch record decoder top level: input register, parser, output register.
// Depends on srd_pkg and srd_parser.
//
// Usage:
//   Input channel (in_valid/in_ready, stream_byte) takes the raw bytes of the
//   stitch data region, one word per cycle. Output channel (out_valid/
//   out_ready, delta_x, delta_y, stitch_kind) gives one decoded record for
//   each plain, big-jump, control-delta or stop record; skipped control
//   records give nothing.
//   A byte that closes a record is held in the input register; its record
//   is loaded into the result register when the parse step takes that byte.
//   Throughput: one byte per cycle while no closing byte waits on a full
//   result register, set by the combinational parse step between the two
//   registers.
//   Stall: while a result waits, bytes that close no record keep flowing;
//   a byte that closes a record holds in the input register until the
//   result register frees, and in_ready drops only then.
//   Reset: the parser returns to expecting a lead byte with no pending
//   trim, and both registers are emptied.
`default_nettype none

module stitch_record_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output wire logic               in_ready,
    input  wire logic [7:0]         stream_byte,
    output wire logic               out_valid,
    input  wire logic               out_ready,
    output wire logic signed [15:0] delta_x,
    output wire logic signed [15:0] delta_y,
    output wire logic [1:0]         stitch_kind
);

    logic               byte_valid_reg;
    logic [7:0]         byte_reg;
    logic               out_valid_reg;
    srd_pkg::record_t   out_rec_reg;
    srd_pkg::result_t   result;
    logic               slot_free;
    logic               step;

    // Consume the held byte unless its record has nowhere to go
    assign slot_free = !out_valid_reg || out_ready;
    assign step      = byte_valid_reg && (!result.emit || slot_free);
    assign in_ready  = !byte_valid_reg || step;

    srd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_reg),
        .step    (step),
        .result  (result)
    );

    // Hold the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= stream_byte;
        end
    end

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && result.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
        begin
            out_rec_reg <= result.rec;
        end
    end

    assign out_valid   = out_valid_reg;
    assign delta_x     = out_rec_reg.dx;
    assign delta_y     = out_rec_reg.dy;
    assign stitch_kind = out_rec_reg.kind;

    // A stop word never carries a move
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_rec_reg.kind == srd_pkg::KIND_STOP |->
            delta_x == 16'sd0 && delta_y == 16'sd0)
        else $error("stop word with non-zero move");

    // A closing byte blocked by a full result register stays held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && byte_valid_reg && result.emit |=>
            byte_valid_reg && $stable(byte_reg))
        else $error("closing byte lost while output stalled");

    // Back-pressure only ever comes from a held byte that cannot move
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> byte_valid_reg && result.emit && out_valid_reg && !out_ready)
        else $error("input stalled without cause");

endmodule

`default_nettype wire

// ----- dv/stitch_record_decoder_test.sv -----
// Self-checking bench for stitch_record_decoder: byte stream in, stitch records out.
// Depends on srd_pkg, srd_parser and stitch_record_decoder; needs no other files.
`timescale 1ns / 100ps

module stitch_record_decoder_test;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned PHASE_BYTES = 195;

    // Track parser state and hold the stitch records still owed by the block
    class stitch_record_tracker;
        srd_pkg::phase_t  phase;
        logic [7:0]       lead;
        logic [7:0]       low_byte;
        logic [15:0]      jump_dx;
        bit               trim_owed;
        srd_pkg::record_t owed_records[$];
        int unsigned      errors;

        function new();
            phase = srd_pkg::PH_LEAD;
            lead = 8'h00;
            low_byte = 8'h00;
            jump_dx = 16'h0000;
            trim_owed = 1'b0;
            errors = 0;
        endfunction

        function automatic logic [15:0] widen(logic [7:0] b);
            return {{8{b[7]}}, b};
        endfunction

        function void owe(logic [15:0] dx, logic [15:0] dy, srd_pkg::kind_t kind);
            srd_pkg::record_t rec;
            rec.dx = dx;
            rec.dy = dy;
            rec.kind = kind;
            owed_records.push_back(rec);
        endfunction

        // Advance the parser by one accepted word
        function void take_byte(logic [7:0] b);
            srd_pkg::kind_t kind;
            case (phase)
                srd_pkg::PH_SECOND:
                begin
                    kind = trim_owed ? srd_pkg::KIND_TRIM : srd_pkg::KIND_NORMAL;
                    trim_owed = 1'b0;
                    phase = srd_pkg::PH_LEAD;
                    if (lead == srd_pkg::LEAD_JUMP_A || lead == srd_pkg::LEAD_JUMP_B)
                    begin
                        low_byte = b;
                        phase = srd_pkg::PH_JX_HI;
                    end
                    else if (lead == srd_pkg::LEAD_CTRL)
                    begin
                        // stop drops any earlier trim, then owes one again
                        if (b != srd_pkg::CTRL_SKIP_A && b != srd_pkg::CTRL_SKIP_B
                            && b >= srd_pkg::CTRL_STOP_MIN)
                        begin
                            trim_owed = 1'b1;
                            owe(16'h0000, 16'h0000, srd_pkg::KIND_STOP);
                        end
                        else if (b == srd_pkg::CTRL_DELTA)
                            phase = srd_pkg::PH_C1_FIRST;
                    end
                    else
                        owe(widen(lead), widen(b), kind);
                end
                srd_pkg::PH_JX_HI:
                begin
                    jump_dx = {b, low_byte};
                    phase = srd_pkg::PH_JY_LO;
                end
                srd_pkg::PH_JY_LO:
                begin
                    low_byte = b;
                    phase = srd_pkg::PH_JY_HI;
                end
                srd_pkg::PH_JY_HI:
                begin
                    owe(jump_dx, {b, low_byte}, srd_pkg::KIND_TRIM);
                    phase = srd_pkg::PH_LEAD;
                end
                srd_pkg::PH_C1_FIRST:
                begin
                    lead = b;
                    phase = srd_pkg::PH_C1_SECOND;
                end
                srd_pkg::PH_C1_SECOND:
                begin
                    owe(widen(lead), widen(b), srd_pkg::KIND_TRIM);
                    phase = srd_pkg::PH_LEAD;
                end
                default:
                begin
                    lead = b;
                    phase = srd_pkg::PH_SECOND;
                end
            endcase
        endfunction

        // Compare one delivered record with the oldest owed one
        function void check_record(logic [15:0] dx, logic [15:0] dy, logic [1:0] kind);
            srd_pkg::record_t exp_rec;
            if (owed_records.size() == 0)
            begin
                $display("%0t: record dx=%h dy=%h kind=%0d with none owed",
                         $time, dx, dy, kind);
                errors++;
                return;
            end
            exp_rec = owed_records.pop_front();
            if (dx !== exp_rec.dx)
            begin
                $display("%0t: delta_x expected %h got %h", $time, exp_rec.dx, dx);
                errors++;
            end
            if (dy !== exp_rec.dy)
            begin
                $display("%0t: delta_y expected %h got %h", $time, exp_rec.dy, dy);
                errors++;
            end
            if (kind !== exp_rec.kind)
            begin
                $display("%0t: stitch_kind expected %0d got %0d",
                         $time, exp_rec.kind, kind);
                errors++;
            end
        endfunction

        function int unsigned owed_count();
            return owed_records.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         stream_byte;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [1:0]         stitch_kind;

    stitch_record_tracker tracker = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_off_len = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;

    stitch_record_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .stitch_kind (stitch_kind)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sample the output channel mid-cycle, where every signal is settled
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_record(delta_x, delta_y, stitch_kind);
    end

    // Drive out_ready: random stalls, or a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word and hold it until taken; then idle at random
    task automatic send_byte(input logic [7:0] value);
        in_valid <= 1'b1;
        stream_byte <= value;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        tracker.take_byte(value);
        bytes_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Pause the sender until every owed record has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.owed_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_plain();
        logic [7:0] lead;
        lead = 8'($urandom_range(255));
        if (lead == srd_pkg::LEAD_JUMP_A || lead == srd_pkg::LEAD_JUMP_B
            || lead == srd_pkg::LEAD_CTRL)
            lead = lead ^ 8'h80;
        send_byte(lead);
        send_byte(8'($urandom_range(255)));
    endtask

    // Send one record of random shape and content, or a little noise
    task automatic send_random_record();
        int unsigned sel;
        logic [7:0]  code;
        sel = $urandom_range(99);
        if (sel < 40)
            send_plain();
        else if (sel < 55)
        begin
            send_byte($urandom_range(1) ? srd_pkg::LEAD_JUMP_A : srd_pkg::LEAD_JUMP_B);
            repeat (4) send_byte(8'($urandom_range(255)));
        end
        else if (sel < 70)
        begin
            code = 8'($urandom_range(255, 8));
            if (code == srd_pkg::CTRL_SKIP_A || code == srd_pkg::CTRL_SKIP_B)
                code = srd_pkg::CTRL_STOP_MIN;
            send_byte(srd_pkg::LEAD_CTRL);
            send_byte(code);
        end
        else if (sel < 82)
        begin
            send_byte(srd_pkg::LEAD_CTRL);
            send_byte(srd_pkg::CTRL_DELTA);
            repeat (2) send_byte(8'($urandom_range(255)));
        end
        else if (sel < 90)
        begin
            case ($urandom_range(7))
                0: code = srd_pkg::CTRL_SKIP_A;
                1: code = srd_pkg::CTRL_SKIP_B;
                2: code = 8'h00;
                default: code = 8'($urandom_range(7, 2));
            endcase
            send_byte(srd_pkg::LEAD_CTRL);
            send_byte(code);
        end
        else
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        logic [7:0]  directed[$];
        int unsigned phase_end;

        rst_n = 1'b0;
        in_valid = 1'b0;
        stream_byte = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, big jumps, stop, skips, control delta and trim carry
        directed = '{8'h00, 8'h00, 8'h80, 8'h7F,
                     srd_pkg::LEAD_JUMP_A, 8'h00, 8'h80, 8'hFF, 8'h7F,
                     srd_pkg::LEAD_CTRL, srd_pkg::CTRL_STOP_MIN, 8'h01, 8'hFF,
                     srd_pkg::LEAD_CTRL, srd_pkg::CTRL_SKIP_A,
                     srd_pkg::LEAD_CTRL, 8'hFF,
                     srd_pkg::LEAD_JUMP_B, 8'hFF, 8'h7F, 8'h00, 8'h80,
                     srd_pkg::LEAD_CTRL, 8'hFF,
                     srd_pkg::LEAD_CTRL, srd_pkg::CTRL_SKIP_B, 8'h05, 8'h06,
                     srd_pkg::LEAD_CTRL, 8'h08,
                     srd_pkg::LEAD_CTRL, srd_pkg::CTRL_DELTA, 8'h80, 8'h7F,
                     srd_pkg::LEAD_CTRL, 8'h07};
        foreach (directed[i])
            send_byte(directed[i]);
        drain();

        // Random phases: none, sender idle, receiver stall, both
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 53;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 53;
                    // hold the receiver off while plain records pile up
                    hold_off_len = 200;
                    repeat (30) send_plain();
                end
                default:
                begin
                    send_idle_pct = 31;
                    recv_stall_pct = 31;
                end
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
                send_random_record();
            drain();
        end

        if (tracker.errors == 0 && tracker.owed_count() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
